// ===== hw/rtl/vector_shape_record_parser_core_defines.svh =====
// ------------------------------------------------------------------------
// Shape record parser assertion macros
// Shared assertion forms, clocked on i_clk, off while reset is low.
// ------------------------------------------------------------------------
`ifndef VECTOR_SHAPE_RECORD_PARSER_CORE_DEFINES_SVH
`define VECTOR_SHAPE_RECORD_PARSER_CORE_DEFINES_SVH

// Check a condition at every edge
`define VSRP_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// Check that a condition implies another at the next edge
`define VSRP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/vsrp_pkg.sv =====
// ------------------------------------------------------------------------
// Shape record parser package
// Record kinds, register indexes, parse phases, result word and helpers.
// ------------------------------------------------------------------------
`default_nettype none

package vsrp_pkg;

    // Record kinds
    localparam logic [2:0] KIND_MOVE  = 3'd0;
    localparam logic [2:0] KIND_STYLE = 3'd1;
    localparam logic [2:0] KIND_LINE  = 3'd2;
    localparam logic [2:0] KIND_CURVE = 3'd3;
    localparam logic [2:0] KIND_END   = 3'd4;
    localparam logic [2:0] KIND_NEWST = 3'd5;

    // Configuration register indexes
    localparam logic CFG_FILL_BITS = 1'b0;
    localparam logic CFG_LINE_BITS = 1'b1;

    localparam logic [4:0] HDR_BITS   = 5'd6;
    localparam logic [4:0] MBITS_BITS = 5'd5;

    typedef enum logic [16:0] {
        PH_HDR   = 17'h00001,
        PH_GEN   = 17'h00002,
        PH_VERT  = 17'h00004,
        PH_LX    = 17'h00008,
        PH_LY    = 17'h00010,
        PH_LONE  = 17'h00020,
        PH_CX    = 17'h00040,
        PH_CY    = 17'h00080,
        PH_AX    = 17'h00100,
        PH_AY    = 17'h00200,
        PH_MBITS = 17'h00400,
        PH_MX    = 17'h00800,
        PH_MY    = 17'h01000,
        PH_F0    = 17'h02000,
        PH_F1    = 17'h04000,
        PH_LS    = 17'h08000,
        PH_SDISP = 17'h10000
    } t_phase;

    typedef struct packed {
        logic [2:0]         record_kind;
        logic signed [30:0] delta_x;
        logic signed [30:0] delta_y;
        logic signed [16:0] anchor_x;
        logic signed [16:0] anchor_y;
        logic               has_fill0;
        logic [14:0]        fill0_index;
        logic               has_fill1;
        logic [14:0]        fill1_index;
        logic               has_line_style;
        logic [14:0]        line_style_index;
        logic               last;
    } t_result;

    localparam int RESULT_W = $bits(t_result);

    // Sign-extend the low w bits of a field; a zero-width field reads as zero
    function automatic logic [30:0] sext_field(input logic [30:0] v, input logic [4:0] w);
        logic [30:0] mask;
        logic        sgn;
        mask = ~(31'h7fffffff << w);
        sgn  = (w == 5'd0) ? 1'b0 : v[w - 5'd1];
        if (w == 5'd0) begin
            sext_field = '0;
        end else begin
            sext_field = (v & mask) | (sgn ? ~mask : 31'd0);
        end
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/vector_shape_record_parser_core.sv =====
// ------------------------------------------------------------------------
// Vector shape record parser core
// Parses a packed shape-record bitstream into one result per record.
// ------------------------------------------------------------------------
// Bytes enter a short input queue and are decoded one bit per cycle, MSB
// first, by the bit engine, which sets the rate; it holds while a result
// waits on a full output queue. Results leave through an output queue.
// After the bits of a byte, a closing step releases any held result and
// loads the next byte if one is already waiting; a byte that finds the
// engine idle takes a separate load step. Each zero-width field and each
// style-flag dispatch step it triggers takes a step of its own. An end
// record or a new-styles halt drops the remaining bits at once, and once
// halted each byte is only closed. Style index widths are taken from the
// registers at the first header bit of each record list.
`default_nettype none

module vector_shape_record_parser_core #(
    parameter int IN_DEPTH  = 2,
    parameter int OUT_DEPTH = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [3:0]  i_cfg_data,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  i_stream_byte,
    output logic             empty,
    input  wire logic        pop,
    output logic [2:0]        o_record_kind,
    output logic signed [30:0] o_delta_x,
    output logic signed [30:0] o_delta_y,
    output logic signed [16:0] o_anchor_x,
    output logic signed [16:0] o_anchor_y,
    output logic             o_has_fill0,
    output logic [14:0]      o_fill0_index,
    output logic             o_has_fill1,
    output logic [14:0]      o_fill1_index,
    output logic             o_has_line_style,
    output logic [14:0]      o_line_style_index,
    output logic             o_last
);

    logic [3:0]        r_fill_bits, r_line_bits;
    logic [7:0]        byte_data;
    logic              byte_empty, byte_pop;
    logic              res_push, res_full;
    vsrp_pkg::t_result res_in, res_out;
    logic [vsrp_pkg::RESULT_W-1:0] res_out_bits;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill_bits <= '0;
            r_line_bits <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == vsrp_pkg::CFG_FILL_BITS) begin
                r_fill_bits <= i_cfg_data;
            end else begin
                r_line_bits <= i_cfg_data;
            end
        end
    end

    vsrp_fifo #(.W(8), .DEPTH(IN_DEPTH)) u_in_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (i_stream_byte),
        .o_full  (full),
        .i_pop   (byte_pop),
        .o_data  (byte_data),
        .o_empty (byte_empty)
    );

    vsrp_parse u_parse (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fill_bits  (r_fill_bits),
        .i_line_bits  (r_line_bits),
        .i_byte       (byte_data),
        .i_byte_empty (byte_empty),
        .o_byte_pop   (byte_pop),
        .o_push       (res_push),
        .o_result     (res_in),
        .i_out_full   (res_full)
    );

    vsrp_fifo #(.W(vsrp_pkg::RESULT_W), .DEPTH(OUT_DEPTH)) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_out_bits),
        .o_empty (empty)
    );

    assign res_out            = vsrp_pkg::t_result'(res_out_bits);
    assign o_record_kind      = res_out.record_kind;
    assign o_delta_x          = res_out.delta_x;
    assign o_delta_y          = res_out.delta_y;
    assign o_anchor_x         = res_out.anchor_x;
    assign o_anchor_y         = res_out.anchor_y;
    assign o_has_fill0        = res_out.has_fill0;
    assign o_fill0_index      = res_out.fill0_index;
    assign o_has_fill1        = res_out.has_fill1;
    assign o_fill1_index      = res_out.fill1_index;
    assign o_has_line_style   = res_out.has_line_style;
    assign o_line_style_index = res_out.line_style_index;
    assign o_last             = res_out.last;

endmodule

`default_nettype wire

// ===== hw/rtl/vsrp_fifo.sv =====
// ------------------------------------------------------------------------
// Shape record parser queue
// Small first-word-fall-through queue of register slots.
// ------------------------------------------------------------------------
`default_nettype none

module vsrp_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire logic [W-1:0] i_data,
    output logic              o_full,
    input  wire logic         i_pop,
    output logic [W-1:0]      o_data,
    output logic              o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_count;
    logic          wr_en, rd_en;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    // Store the word at the write slot
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (wr_en) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (rd_en) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + 1'b1;
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/vsrp_parse.sv =====
// ------------------------------------------------------------------------
// Shape record parser bit engine
// Shifts each byte out MSB first, walks the record fields and builds
// one result word per decoded record.
// ------------------------------------------------------------------------
`default_nettype none

`include "vector_shape_record_parser_core_defines.svh"

module vsrp_parse (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic [3:0]        i_fill_bits,
    input  wire logic [3:0]        i_line_bits,
    input  wire logic [7:0]        i_byte,
    input  wire logic              i_byte_empty,
    output logic                   o_byte_pop,
    output logic                   o_push,
    output vsrp_pkg::t_result      o_result,
    input  wire logic              i_out_full
);

    vsrp_pkg::t_phase  r_phase, n_phase;
    logic [4:0]        r_bits_rem, n_bits_rem;
    logic [30:0]       r_shift, n_shift;
    logic [5:0]        r_flags, n_flags;
    logic [4:0]        r_fwidth, n_fwidth;
    logic [1:0]        r_stage, n_stage;
    logic [30:0]       r_held_x, n_held_x;
    logic [30:0]       r_held_y, n_held_y;
    logic [16:0]       r_held_ax, n_held_ax;
    logic [14:0]       r_held_f0, n_held_f0;
    logic [14:0]       r_held_f1, n_held_f1;
    logic [14:0]       r_held_ls, n_held_ls;
    logic              r_vert, n_vert;
    logic [3:0]        r_cur_fw, n_cur_fw;
    logic [3:0]        r_cur_lw, n_cur_lw;
    logic              r_halted, n_halted;
    logic              r_list_start, n_list_start;
    logic              r_align, n_align;
    logic [7:0]        r_byte, n_byte;
    logic [3:0]        r_bits_left, n_bits_left;
    logic              r_active, n_active;
    vsrp_pkg::t_result r_pend, n_pend;
    logic              r_pend_valid, n_pend_valid;

    logic              can_go, zw, consume, byte_end, fin, emit, go;
    logic [30:0]       v, sx;
    logic [4:0]        hdr_fw, nw;
    vsrp_pkg::t_phase  nph;
    vsrp_pkg::t_result e;

    always_comb begin
        n_phase      = r_phase;
        n_bits_rem   = r_bits_rem;
        n_shift      = r_shift;
        n_flags      = r_flags;
        n_fwidth     = r_fwidth;
        n_stage      = r_stage;
        n_held_x     = r_held_x;
        n_held_y     = r_held_y;
        n_held_ax    = r_held_ax;
        n_held_f0    = r_held_f0;
        n_held_f1    = r_held_f1;
        n_held_ls    = r_held_ls;
        n_vert       = r_vert;
        n_cur_fw     = r_cur_fw;
        n_cur_lw     = r_cur_lw;
        n_halted     = r_halted;
        n_list_start = r_list_start;
        n_align      = r_align;
        n_byte       = r_byte;
        n_bits_left  = r_bits_left;
        n_active     = r_active;
        n_pend       = r_pend;
        n_pend_valid = r_pend_valid;
        o_byte_pop   = 1'b0;
        o_push       = 1'b0;
        o_result     = r_pend;
        emit         = 1'b0;
        e            = '0;
        go           = 1'b0;
        nph          = vsrp_pkg::PH_HDR;
        nw           = vsrp_pkg::HDR_BITS;
        fin          = 1'b0;
        v            = r_shift;
        hdr_fw       = 5'd0;
        sx           = vsrp_pkg::sext_field(v, r_fwidth);

        can_go   = !(r_pend_valid && i_out_full);
        zw       = r_active && (r_bits_rem == 5'd0);
        consume  = r_active && !zw && (r_bits_left != 4'd0) && !r_halted && !r_align;
        byte_end = r_active && !zw && !consume;

        if (can_go && (zw || consume)) begin
            fin = zw;
            // Shift in the next stream bit
            if (consume) begin
                if ((r_phase == vsrp_pkg::PH_HDR) && (r_bits_rem == vsrp_pkg::HDR_BITS)
                        && r_list_start) begin
                    n_cur_fw     = i_fill_bits;
                    n_cur_lw     = i_line_bits;
                    n_list_start = 1'b0;
                end
                v           = {r_shift[29:0], r_byte[7]};
                n_shift     = v;
                n_byte      = {r_byte[6:0], 1'b0};
                n_bits_left = r_bits_left - 4'd1;
                n_bits_rem  = r_bits_rem - 5'd1;
                fin         = (r_bits_rem == 5'd1);
            end
            sx = vsrp_pkg::sext_field(v, r_fwidth);
            // Close the field and pick the next one
            if (fin) begin
                go = 1'b1;
                case (r_phase)
                    vsrp_pkg::PH_HDR: begin
                        n_flags  = v[5:0];
                        hdr_fw   = {1'b0, v[3:0]} + 5'd2;
                        n_fwidth = hdr_fw;
                        if (!v[5] && (v[4:0] == 5'd0)) begin
                            emit          = 1'b1;
                            e.record_kind = vsrp_pkg::KIND_END;
                            n_list_start  = 1'b1;
                            n_align       = 1'b1;
                        end else if (v[5]) begin
                            nph = v[4] ? vsrp_pkg::PH_GEN : vsrp_pkg::PH_CX;
                            nw  = v[4] ? 5'd1 : hdr_fw;
                        end else if (v[0]) begin
                            nph = vsrp_pkg::PH_MBITS;
                            nw  = vsrp_pkg::MBITS_BITS;
                        end else begin
                            nph     = vsrp_pkg::PH_SDISP;
                            nw      = 5'd0;
                            n_stage = 2'd0;
                        end
                    end
                    vsrp_pkg::PH_GEN: begin
                        nph = v[0] ? vsrp_pkg::PH_LX : vsrp_pkg::PH_VERT;
                        nw  = v[0] ? r_fwidth : 5'd1;
                    end
                    vsrp_pkg::PH_VERT: begin
                        n_vert = v[0];
                        nph    = vsrp_pkg::PH_LONE;
                        nw     = r_fwidth;
                    end
                    vsrp_pkg::PH_LX: begin
                        n_held_x = sx;
                        nph      = vsrp_pkg::PH_LY;
                        nw       = r_fwidth;
                    end
                    vsrp_pkg::PH_LY: begin
                        emit          = 1'b1;
                        e.record_kind = vsrp_pkg::KIND_LINE;
                        e.delta_x     = r_held_x;
                        e.delta_y     = sx;
                    end
                    vsrp_pkg::PH_LONE: begin
                        emit          = 1'b1;
                        e.record_kind = vsrp_pkg::KIND_LINE;
                        if (r_vert) begin
                            e.delta_y = sx;
                        end else begin
                            e.delta_x = sx;
                        end
                    end
                    vsrp_pkg::PH_CX: begin
                        n_held_x = sx;
                        nph      = vsrp_pkg::PH_CY;
                        nw       = r_fwidth;
                    end
                    vsrp_pkg::PH_CY: begin
                        n_held_y = sx;
                        nph      = vsrp_pkg::PH_AX;
                        nw       = r_fwidth;
                    end
                    vsrp_pkg::PH_AX: begin
                        n_held_ax = sx[16:0];
                        nph       = vsrp_pkg::PH_AY;
                        nw        = r_fwidth;
                    end
                    vsrp_pkg::PH_AY: begin
                        emit          = 1'b1;
                        e.record_kind = vsrp_pkg::KIND_CURVE;
                        e.delta_x     = r_held_x;
                        e.delta_y     = r_held_y;
                        e.anchor_x    = r_held_ax;
                        e.anchor_y    = sx[16:0];
                    end
                    vsrp_pkg::PH_MBITS: begin
                        n_fwidth = v[4:0];
                        nph      = vsrp_pkg::PH_MX;
                        nw       = v[4:0];
                    end
                    vsrp_pkg::PH_MX: begin
                        n_held_x = sx;
                        nph      = vsrp_pkg::PH_MY;
                        nw       = r_fwidth;
                    end
                    vsrp_pkg::PH_MY: begin
                        emit          = 1'b1;
                        e.record_kind = vsrp_pkg::KIND_MOVE;
                        e.delta_x     = r_held_x;
                        e.delta_y     = sx;
                        if (r_flags[4:1] != 4'd0) begin
                            nph     = vsrp_pkg::PH_SDISP;
                            nw      = 5'd0;
                            n_stage = 2'd0;
                        end
                    end
                    vsrp_pkg::PH_F0: begin
                        n_held_f0 = v[14:0];
                        nph       = vsrp_pkg::PH_SDISP;
                        nw        = 5'd0;
                        n_stage   = 2'd1;
                    end
                    vsrp_pkg::PH_F1: begin
                        n_held_f1 = v[14:0];
                        nph       = vsrp_pkg::PH_SDISP;
                        nw        = 5'd0;
                        n_stage   = 2'd2;
                    end
                    vsrp_pkg::PH_LS: begin
                        n_held_ls = v[14:0];
                        nph       = vsrp_pkg::PH_SDISP;
                        nw        = 5'd0;
                        n_stage   = 2'd3;
                    end
                    vsrp_pkg::PH_SDISP: begin
                        if ((r_stage == 2'd0) && r_flags[1]) begin
                            nph = vsrp_pkg::PH_F0;
                            nw  = {1'b0, r_cur_fw};
                        end else if ((r_stage <= 2'd1) && r_flags[2]) begin
                            nph = vsrp_pkg::PH_F1;
                            nw  = {1'b0, r_cur_fw};
                        end else if ((r_stage <= 2'd2) && r_flags[3]) begin
                            nph = vsrp_pkg::PH_LS;
                            nw  = {1'b0, r_cur_lw};
                        end else begin
                            emit             = 1'b1;
                            e.record_kind    = r_flags[4] ? vsrp_pkg::KIND_NEWST
                                                          : vsrp_pkg::KIND_STYLE;
                            e.has_fill0      = r_flags[1];
                            e.fill0_index    = r_flags[1] ? r_held_f0 : 15'd0;
                            e.has_fill1      = r_flags[2];
                            e.fill1_index    = r_flags[2] ? r_held_f1 : 15'd0;
                            e.has_line_style = r_flags[3];
                            e.line_style_index = r_flags[3] ? r_held_ls : 15'd0;
                            n_halted         = r_flags[4];
                        end
                    end
                    default: begin
                        nph = vsrp_pkg::PH_HDR;
                        nw  = vsrp_pkg::HDR_BITS;
                    end
                endcase
            end
        end else if (can_go && byte_end) begin
            // Close the byte: release the held result marked last, load the next byte if one waits
            if (r_pend_valid) begin
                o_push        = 1'b1;
                o_result      = r_pend;
                o_result.last = 1'b1;
            end
            n_pend_valid = 1'b0;
            n_align      = 1'b0;
            n_active     = 1'b0;
            if (!i_byte_empty) begin
                o_byte_pop  = 1'b1;
                n_byte      = i_byte;
                n_bits_left = 4'd8;
                n_active    = 1'b1;
            end
        end else if (!r_active && !i_byte_empty) begin
            // Load the next byte
            o_byte_pop  = 1'b1;
            n_byte      = i_byte;
            n_bits_left = 4'd8;
            n_active    = 1'b1;
        end

        if (go) begin
            n_phase    = nph;
            n_bits_rem = nw;
            n_shift    = '0;
        end

        // Hold the newest result; pass the older one on
        if (emit) begin
            if (r_pend_valid) begin
                o_push        = 1'b1;
                o_result      = r_pend;
                o_result.last = 1'b0;
            end
            n_pend       = e;
            n_pend_valid = 1'b1;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= vsrp_pkg::PH_HDR;
            r_bits_rem   <= vsrp_pkg::HDR_BITS;
            r_shift      <= '0;
            r_flags      <= '0;
            r_fwidth     <= '0;
            r_stage      <= '0;
            r_vert       <= 1'b0;
            r_cur_fw     <= '0;
            r_cur_lw     <= '0;
            r_halted     <= 1'b0;
            r_list_start <= 1'b1;
            r_align      <= 1'b0;
            r_bits_left  <= '0;
            r_active     <= 1'b0;
            r_pend_valid <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_bits_rem   <= n_bits_rem;
            r_shift      <= n_shift;
            r_flags      <= n_flags;
            r_fwidth     <= n_fwidth;
            r_stage      <= n_stage;
            r_vert       <= n_vert;
            r_cur_fw     <= n_cur_fw;
            r_cur_lw     <= n_cur_lw;
            r_halted     <= n_halted;
            r_list_start <= n_list_start;
            r_align      <= n_align;
            r_bits_left  <= n_bits_left;
            r_active     <= n_active;
            r_pend_valid <= n_pend_valid;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_held_x  <= n_held_x;
        r_held_y  <= n_held_y;
        r_held_ax <= n_held_ax;
        r_held_f0 <= n_held_f0;
        r_held_f1 <= n_held_f1;
        r_held_ls <= n_held_ls;
        r_byte    <= n_byte;
        r_pend    <= n_pend;
    end

    `VSRP_ASSERT_NEXT(a_halt_sticks, r_halted, r_halted, "parser left the halted state")
    `VSRP_ASSERT_ALWAYS(a_zw_in_byte, (r_bits_rem != 5'd0) || r_active, "zero-width step outside a byte")
    `VSRP_ASSERT_ALWAYS(a_no_overrun, !o_push || !i_out_full, "result pushed into full queue")
    `VSRP_ASSERT_ALWAYS(a_pend_kind, !r_pend_valid || (r_pend.record_kind <= vsrp_pkg::KIND_NEWST), "held result has a bad kind")

endmodule

`default_nettype wire

// ===== tb/tb_vector_shape_record_parser_core.sv =====
// ------------------------------------------------------------------------
// Shape record parser core testbench
// Builds shape-record bitstreams (lines, curves, moves, style changes and
// end records), feeds them as words, predicts every decoded record and
// checks each result word against the prediction, field by field.
// ------------------------------------------------------------------------
`default_nettype none

class shape_scoreboard;
    vsrp_pkg::t_result exp_q[$];
    vsrp_pkg::t_result burst[$];
    int                errors;
    bit [3:0]          reg_fill, reg_line, cur_fill, cur_line;
    vsrp_pkg::t_phase  ph;
    int unsigned       remaining, fw, flags;
    bit [31:0]         shift;
    longint            held_x, held_y, held_ax;
    bit [14:0]         held_f0, held_f1, held_ls;
    bit                halted, vert, list_start, align;

    function new();
        errors   = 0;
        reg_fill = 0;
        reg_line = 0;
        cur_fill = 0;
        cur_line = 0;
        ph       = vsrp_pkg::PH_HDR;
        remaining = 6;
        fw       = 0;
        flags    = 0;
        shift    = 0;
        held_x   = 0;
        held_y   = 0;
        held_ax  = 0;
        held_f0  = 0;
        held_f1  = 0;
        held_ls  = 0;
        halted   = 0;
        vert     = 0;
        list_start = 1;
        align    = 0;
    endfunction

    function void write_reg(logic idx, bit [3:0] val);
        if (idx == vsrp_pkg::CFG_FILL_BITS) reg_fill = val;
        else reg_line = val;
    endfunction

    // Sign-extend the low w bits; zero width reads as zero
    function longint sx(bit [31:0] v, int unsigned w);
        longint m;
        longint vv;
        if (w == 0 || w > 32) return 0;
        m  = (64'sd1 <<< w) - 1;
        vv = longint'({32'd0, v}) & m;
        if ((vv >>> (w - 1)) & 1) return vv - (64'sd1 <<< w);
        return vv;
    endfunction

    function void emit(logic [2:0] kind, longint dx, longint dy, longint ax, longint ay,
                       bit style);
        vsrp_pkg::t_result r;
        r = '0;
        r.record_kind      = kind;
        r.delta_x          = 31'(dx);
        r.delta_y          = 31'(dy);
        r.anchor_x         = 17'(ax);
        r.anchor_y         = 17'(ay);
        r.has_fill0        = style && flags[1];
        r.fill0_index      = r.has_fill0 ? held_f0 : 15'd0;
        r.has_fill1        = style && flags[2];
        r.fill1_index      = r.has_fill1 ? held_f1 : 15'd0;
        r.has_line_style   = style && flags[3];
        r.line_style_index = r.has_line_style ? held_ls : 15'd0;
        if (burst.size() < 3) burst.push_back(r);
    endfunction

    function void start(vsrp_pkg::t_phase p, int unsigned w);
        ph        = p;
        remaining = w & 31;
        shift     = 0;
        if (remaining == 0) close_field();
    endfunction

    // Walk the style flags in order: fill0, fill1, line, then new styles
    function void style_next(int stage);
        int unsigned f;
        f = flags & 31;
        if (stage == 0 && f[1]) begin start(vsrp_pkg::PH_F0, cur_fill); return; end
        if (stage <= 1 && f[2]) begin start(vsrp_pkg::PH_F1, cur_fill); return; end
        if (stage <= 2 && f[3]) begin start(vsrp_pkg::PH_LS, cur_line); return; end
        if (f[4]) begin
            emit(vsrp_pkg::KIND_NEWST, 0, 0, 0, 0, 1);
            halted    = 1;
            ph        = vsrp_pkg::PH_HDR;
            remaining = 6;
            return;
        end
        emit(vsrp_pkg::KIND_STYLE, 0, 0, 0, 0, 1);
        start(vsrp_pkg::PH_HDR, 6);
    endfunction

    function void close_field();
        bit [31:0]   v;
        int unsigned f;
        v = shift;
        f = flags & 31;
        case (ph)
            vsrp_pkg::PH_HDR: begin
                flags = v & 63;
                f     = flags & 31;
                fw    = (f & 15) + 2;
                if (!flags[5] && f == 0) begin
                    emit(vsrp_pkg::KIND_END, 0, 0, 0, 0, 0);
                    list_start = 1;
                    align      = 1;
                    start(vsrp_pkg::PH_HDR, 6);
                end else if (flags[5]) begin
                    if (f[4]) start(vsrp_pkg::PH_GEN, 1);
                    else start(vsrp_pkg::PH_CX, fw);
                end else if (f[0]) begin
                    start(vsrp_pkg::PH_MBITS, 5);
                end else begin
                    style_next(0);
                end
            end
            vsrp_pkg::PH_GEN: begin
                if (v[0]) start(vsrp_pkg::PH_LX, fw);
                else start(vsrp_pkg::PH_VERT, 1);
            end
            vsrp_pkg::PH_VERT: begin
                vert = v[0];
                start(vsrp_pkg::PH_LONE, fw);
            end
            vsrp_pkg::PH_LX: begin
                held_x = sx(v, fw);
                start(vsrp_pkg::PH_LY, fw);
            end
            vsrp_pkg::PH_LY: begin
                emit(vsrp_pkg::KIND_LINE, held_x, sx(v, fw), 0, 0, 0);
                start(vsrp_pkg::PH_HDR, 6);
            end
            vsrp_pkg::PH_LONE: begin
                if (vert) emit(vsrp_pkg::KIND_LINE, 0, sx(v, fw), 0, 0, 0);
                else emit(vsrp_pkg::KIND_LINE, sx(v, fw), 0, 0, 0, 0);
                start(vsrp_pkg::PH_HDR, 6);
            end
            vsrp_pkg::PH_CX: begin
                held_x = sx(v, fw);
                start(vsrp_pkg::PH_CY, fw);
            end
            vsrp_pkg::PH_CY: begin
                held_y = sx(v, fw);
                start(vsrp_pkg::PH_AX, fw);
            end
            vsrp_pkg::PH_AX: begin
                held_ax = sx(v, fw);
                start(vsrp_pkg::PH_AY, fw);
            end
            vsrp_pkg::PH_AY: begin
                emit(vsrp_pkg::KIND_CURVE, held_x, held_y, held_ax, sx(v, fw), 0);
                start(vsrp_pkg::PH_HDR, 6);
            end
            vsrp_pkg::PH_MBITS: begin
                fw = v & 31;
                start(vsrp_pkg::PH_MX, fw);
            end
            vsrp_pkg::PH_MX: begin
                held_x = sx(v, fw);
                start(vsrp_pkg::PH_MY, fw);
            end
            vsrp_pkg::PH_MY: begin
                emit(vsrp_pkg::KIND_MOVE, held_x, sx(v, fw), 0, 0, 0);
                if (f & 30) style_next(0);
                else start(vsrp_pkg::PH_HDR, 6);
            end
            vsrp_pkg::PH_F0: begin
                held_f0 = v[14:0];
                style_next(1);
            end
            vsrp_pkg::PH_F1: begin
                held_f1 = v[14:0];
                style_next(2);
            end
            vsrp_pkg::PH_LS: begin
                held_ls = v[14:0];
                style_next(3);
            end
            default: start(vsrp_pkg::PH_HDR, 6);
        endcase
    endfunction

    // Decode one accepted word and queue the records it completes
    function void note_word(bit [7:0] b);
        burst.delete();
        align = 0;
        for (int i = 7; i >= 0; i--) begin
            if (halted || align) break;
            if (ph == vsrp_pkg::PH_HDR && remaining == 6 && list_start) begin
                cur_fill   = reg_fill;
                cur_line   = reg_line;
                list_start = 0;
            end
            if (remaining == 0) begin
                start(vsrp_pkg::PH_HDR, 6);
                continue;
            end
            shift = {shift[30:0], b[i]};
            remaining--;
            if (remaining == 0) close_field();
        end
        align = 0;
        if (burst.size() > 0) burst[burst.size() - 1].last = 1'b1;
        foreach (burst[k]) exp_q.push_back(burst[k]);
    endfunction

    function void cmp(string name, longint e, longint a);
        if (e != a) begin
            $error("%s: expected %0d, got %0d", name, e, a);
            errors++;
        end
    endfunction

    function void check_result(vsrp_pkg::t_result got);
        vsrp_pkg::t_result e;
        if (exp_q.size() == 0) begin
            $error("unexpected result word, kind %0d", got.record_kind);
            errors++;
            return;
        end
        e = exp_q.pop_front();
        cmp("record_kind", e.record_kind, got.record_kind);
        cmp("delta_x", e.delta_x, got.delta_x);
        cmp("delta_y", e.delta_y, got.delta_y);
        cmp("anchor_x", e.anchor_x, got.anchor_x);
        cmp("anchor_y", e.anchor_y, got.anchor_y);
        cmp("has_fill0", e.has_fill0, got.has_fill0);
        cmp("fill0_index", e.fill0_index, got.fill0_index);
        cmp("has_fill1", e.has_fill1, got.has_fill1);
        cmp("fill1_index", e.fill1_index, got.fill1_index);
        cmp("has_line_style", e.has_line_style, got.has_line_style);
        cmp("line_style_index", e.line_style_index, got.line_style_index);
        cmp("last", e.last, got.last);
    endfunction
endclass

module tb_vector_shape_record_parser_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 300000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_idx = 1'b0;
    logic [3:0]  i_cfg_data = 4'd0;
    logic        push = 1'b0;
    logic        full;
    logic [7:0]  i_stream_byte = 8'd0;
    logic        empty;
    logic        pop = 1'b0;
    logic [2:0]  o_record_kind;
    logic signed [30:0] o_delta_x, o_delta_y;
    logic signed [16:0] o_anchor_x, o_anchor_y;
    logic        o_has_fill0, o_has_fill1, o_has_line_style, o_last;
    logic [14:0] o_fill0_index, o_fill1_index, o_line_style_index;

    shape_scoreboard sb = new();
    bit   bitq[$];
    bit   quiet = 0;
    int   n_words = 0;
    int   cycles = 0;
    int   pop_hold = 0;
    int   fill_w = 0;
    int   line_w = 0;

    vector_shape_record_parser_core uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .push(push), .full(full), .i_stream_byte(i_stream_byte),
        .empty(empty), .pop(pop),
        .o_record_kind(o_record_kind), .o_delta_x(o_delta_x), .o_delta_y(o_delta_y),
        .o_anchor_x(o_anchor_x), .o_anchor_y(o_anchor_y),
        .o_has_fill0(o_has_fill0), .o_fill0_index(o_fill0_index),
        .o_has_fill1(o_has_fill1), .o_fill1_index(o_fill1_index),
        .o_has_line_style(o_has_line_style), .o_line_style_index(o_line_style_index),
        .o_last(o_last)
    );

    always #5 i_clk = ~i_clk;

    // Bound the run
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_vector_shape_record_parser_core failed");
            $finish;
        end
    end

    // Pop with random stall bursts
    always @(negedge i_clk) begin
        if (pop_hold > 0) begin
            pop_hold--;
            pop = 1'b0;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            pop_hold = $urandom_range(0, 6);
            pop = 1'b0;
        end else begin
            pop = 1'b1;
        end
    end

    // Check each popped result word
    always @(posedge i_clk) begin
        vsrp_pkg::t_result got;
        if (i_rst_n && pop && !empty) begin
            got.record_kind      = o_record_kind;
            got.delta_x          = o_delta_x;
            got.delta_y          = o_delta_y;
            got.anchor_x         = o_anchor_x;
            got.anchor_y         = o_anchor_y;
            got.has_fill0        = o_has_fill0;
            got.fill0_index      = o_fill0_index;
            got.has_fill1        = o_has_fill1;
            got.fill1_index      = o_fill1_index;
            got.has_line_style   = o_has_line_style;
            got.line_style_index = o_line_style_index;
            got.last             = o_last;
            sb.check_result(got);
        end
    end

    // Push one word, holding it until accepted
    task automatic send_word(bit [7:0] b);
        bit taken;
        taken = 0;
        if (!quiet && $urandom_range(0, 4) == 0) begin
            push = 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge i_clk);
        end
        push = 1'b1;
        i_stream_byte = b;
        while (!taken) begin
            @(posedge i_clk);
            taken = !full;
        end
        sb.note_word(b);
        n_words++;
        @(negedge i_clk);
        push = 1'b0;
    endtask

    // Append a field MSB first and ship every complete word
    task automatic put(bit [31:0] v, int w);
        bit [7:0] b;
        for (int i = w - 1; i >= 0; i--) bitq.push_back(v[i]);
        while (bitq.size() >= 8) begin
            for (int i = 7; i >= 0; i--) b[i] = bitq.pop_front();
            send_word(b);
        end
    endtask

    task automatic pad_word();
        while (bitq.size() % 8 != 0) bitq.push_back($urandom_range(0, 1));
        put(0, 0);
    endtask

    function automatic bit [31:0] rv(int w);
        bit [31:0] m;
        if (w == 0) return 0;
        m = (w >= 32) ? 32'hffffffff : (32'd1 << w) - 1;
        case ($urandom_range(0, 5))
            0: return m;
            1: return 32'd1 << (w - 1);
            2: return 0;
            3: return m >> 1;
            default: return $urandom & m;
        endcase
    endfunction

    task automatic line_rec(bit [3:0] ws, bit general, bit vertical, bit [31:0] x, bit [31:0] y);
        put(1, 1);
        put(1, 1);
        put(ws, 4);
        put(general, 1);
        if (general) begin
            put(x, ws + 2);
            put(y, ws + 2);
        end else begin
            put(vertical, 1);
            put(vertical ? y : x, ws + 2);
        end
    endtask

    task automatic curve_rec(bit [3:0] ws, bit [31:0] cx, bit [31:0] cy, bit [31:0] ax,
                             bit [31:0] ay);
        put(1, 1);
        put(0, 1);
        put(ws, 4);
        put(cx, ws + 2);
        put(cy, ws + 2);
        put(ax, ws + 2);
        put(ay, ws + 2);
    endtask

    // Non-edge record; bit 4 of the flags selects new styles
    task automatic style_rec(bit [4:0] fl, int mw, bit [31:0] mx, bit [31:0] my,
                             bit [31:0] f0, bit [31:0] f1, bit [31:0] ls);
        put(0, 1);
        put(fl, 5);
        if (fl[0]) begin
            put(mw, 5);
            put(mx, mw);
            put(my, mw);
        end
        if (fl[1]) put(f0, fill_w);
        if (fl[2]) put(f1, fill_w);
        if (fl[3]) put(ls, line_w);
    endtask

    task automatic end_rec();
        put(0, 6);
        pad_word();
    endtask

    task automatic rand_record();
        bit [3:0] ws;
        int       mw;
        ws = $urandom_range(0, 3) == 0 ? 4'd15 : 4'($urandom_range(0, 15));
        mw = $urandom_range(0, 31);
        case ($urandom_range(0, 9))
            0, 1, 2: line_rec(ws, $urandom_range(0, 1), $urandom_range(0, 1),
                              rv(ws + 2), rv(ws + 2));
            3, 4:    curve_rec(ws, rv(ws + 2), rv(ws + 2), rv(ws + 2), rv(ws + 2));
            5, 6, 7, 8: style_rec({1'b0, 4'($urandom_range(1, 15))}, mw, rv(mw), rv(mw),
                                  rv(fill_w), rv(fill_w), rv(line_w));
            default: end_rec();
        endcase
    endtask

    // Wait out every expected result, then let the core settle
    task automatic drain();
        while (sb.exp_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic set_regs(bit [3:0] f, bit [3:0] l);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = vsrp_pkg::CFG_FILL_BITS;
        i_cfg_data = f;
        @(negedge i_clk);
        i_cfg_idx  = vsrp_pkg::CFG_LINE_BITS;
        i_cfg_data = l;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
        sb.write_reg(vsrp_pkg::CFG_FILL_BITS, f);
        sb.write_reg(vsrp_pkg::CFG_LINE_BITS, l);
        fill_w = f;
        line_w = l;
    endtask

    initial begin
        int target;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: zero-width style indexes, extremes of every delta form
        set_regs(4'd0, 4'd0);
        line_rec(4'd15, 1, 0, 32'h10000, 32'h0ffff);
        line_rec(4'd15, 0, 1, 0, 32'h1ffff);
        line_rec(4'd0, 0, 0, 32'h2, 0);
        curve_rec(4'd0, 32'h1, 32'h2, 32'h3, 32'h0);
        curve_rec(4'd15, 32'h1ffff, 32'h10000, 32'h0ffff, 32'h00001);
        style_rec(5'b00001, 0, 0, 0, 0, 0, 0);
        style_rec(5'b01111, 31, 32'h40000000, 32'h3fffffff, 0, 0, 0);
        style_rec(5'b01000, 0, 0, 0, 0, 0, 0);
        end_rec();
        drain();

        // Directed: widest style indexes
        set_regs(4'd15, 4'd15);
        style_rec(5'b01110, 0, 0, 0, 32'h7fff, 32'h0, 32'h5555);
        style_rec(5'b00111, 1, 32'h1, 32'h0, 32'h0, 32'h7fff, 0);
        end_rec();
        drain();

        // Random record lists over several register settings
        target = n_words;
        for (int p = 0; p < 5; p++) begin
            case (p)
                0: set_regs(4'd1, 4'd0);
                1: set_regs(4'd0, 4'd15);
                4: set_regs(4'd15, 4'd15);
                default: set_regs($urandom_range(0, 15), $urandom_range(0, 15));
            endcase
            quiet = (p == 4);
            target += 45;
            while (n_words < target) rand_record();
            end_rec();
            drain();
        end

        // New styles halts the core; later words must give nothing
        style_rec(5'b10010, 0, 0, 0, 32'h1234, 0, 0);
        pad_word();
        put($urandom, 24);
        drain();

        if (sb.errors == 0) begin
            $display("tb_vector_shape_record_parser_core passed");
        end else begin
            $display("tb_vector_shape_record_parser_core failed");
        end
        $finish;
    end
endmodule

`default_nettype wire
